FILE: src/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/c3cf_pkg.sv
// Types and constants of the 3x3 convolution and clip filter.
package c3cf_pkg;

	localparam int PIXEL_W       = 8;
	localparam int COEFF_REG_W   = 54;
	localparam int WIDTH_REG_W   = 12;
	localparam int HEIGHT_REG_W  = 13;
	localparam int X_OUT_W       = 11;
	localparam int Y_OUT_W       = 12;
	localparam int CLIP_W        = 8;
	localparam int SUM_W         = 18;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 54;
	localparam int WIN_TAPS      = 9;
	localparam int FIFO_DEPTH    = 8;

	localparam int MAX_WIDTH_DEF = 2048;
	localparam int COEF_BITS_DEF = 6;
	localparam int MAX_HEIGHT    = 4096;
	localparam int MIN_SIZE      = 3;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 12'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 13'd480;

	localparam int SUM_HI  = 131071;
	localparam int SUM_LO  = -131072;
	localparam int CLIP_HI = 255;

	localparam logic signed [SUM_W-1:0] SUM_MAX = 18'sh1FFFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN = 18'sh20000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEFF  = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} c3cf_reg_t;

	typedef struct packed {
		logic [X_OUT_W-1:0]       out_x;
		logic [Y_OUT_W-1:0]       out_y;
		logic [CLIP_W-1:0]        clipped;
		logic signed [SUM_W-1:0]  raw_sum;
		logic signed [SUM_W-1:0]  frame_min;
		logic signed [SUM_W-1:0]  frame_max;
		logic                     frame_last;
	} c3cf_result_t;

endpackage

FILE: src/c3cf_if.sv
// Channel interfaces of the filter: pixel input, result output, register writes.
interface c3cf_in_if;
	import c3cf_pkg::*;
	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] pixel;
	logic               frame_start;

	modport source(output valid, pixel, frame_start, input ready);
	modport sink(input valid, pixel, frame_start, output ready);
endinterface

interface c3cf_out_if;
	import c3cf_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [X_OUT_W-1:0]      out_x;
	logic [Y_OUT_W-1:0]      out_y;
	logic [CLIP_W-1:0]       clipped;
	logic signed [SUM_W-1:0] raw_sum;
	logic signed [SUM_W-1:0] frame_min;
	logic signed [SUM_W-1:0] frame_max;
	logic                    frame_last;

	modport source(output valid, out_x, out_y, clipped, raw_sum, frame_min, frame_max,
		frame_last, input ready);
	modport sink(input valid, out_x, out_y, clipped, raw_sum, frame_min, frame_max,
		frame_last, output ready);
endinterface

interface c3cf_cfg_if;
	import c3cf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: src/c3cf_ram.sv
// Generic single write port, single read port RAM with registered read data.
module c3cf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/conv3x3_clip_filter_unit.sv
// Top level of the 3x3 convolution filter with clip and per-frame min/max.
//
//   channel   dir   beat carries
//   pixels    in    pixel, frame_start
//   results   out   out_x, out_y, clipped, raw_sum, frame_min, frame_max, frame_last
//   cfg       in    index, data (always ready)
//
// One pixel beat can be taken every cycle, except while beats are refused as set out
// below. A result passes through line store read, window and nine multiplies, adder
// tree, then saturation, clip and min/max update on its way to the output buffer.
// Pixel beats are refused while eight beats are in flight or buffered as results.
// Reset clears position, window and min/max; the line stores are not cleared.
module conv3x3_clip_filter_unit #(
	parameter int MAX_WIDTH = c3cf_pkg::MAX_WIDTH_DEF,
	parameter int COEF_BITS = c3cf_pkg::COEF_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	c3cf_in_if.sink     pixels,
	c3cf_out_if.source  results,
	c3cf_cfg_if.sink    cfg
);
	import c3cf_pkg::*;

	localparam int AW     = $clog2(MAX_WIDTH);
	localparam int PROD_W = COEF_BITS + PIXEL_W + 1;
	localparam int ACC_W  = PROD_W + 4;
	localparam int CVEC_W = WIN_TAPS * COEF_BITS;
	localparam int PTR_W  = $clog2(FIFO_DEPTH);
	localparam int CNT_W  = PTR_W + 1;

	// Configuration registers
	logic [COEFF_REG_W-1:0]  coeff_q;
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;

	logic [WIDTH_REG_W-1:0]  eff_w;
	logic [HEIGHT_REG_W-1:0] eff_h;
	logic [CVEC_W+COEFF_REG_W-1:0] coeff_wide;
	logic [CVEC_W-1:0]       coef_vec;

	// Position and flow control
	logic [AW-1:0]          col_q;
	logic [Y_OUT_W-1:0]     row_q;
	logic [CNT_W-1:0]       occ_q;
	logic                   accept;
	logic [HEIGHT_REG_W-1:0] c_pre, r_pre, c_nx, r_nx;
	logic                   clrb_pre, clra_pre;
	logic                   fwd_hit;

	// Stage 1: line store data available
	logic                v_s1;
	logic [PIXEL_W-1:0]  pix_s1;
	logic [AW-1:0]       c_s1;
	logic [Y_OUT_W-1:0]  r_s1;
	logic                clrb_s1, clra_s1;
	logic                fwd_s1;
	logic [PIXEL_W-1:0]  a_fwd_s1, b_fwd_s1;
	logic [PIXEL_W-1:0]  rd_a, rd_b;
	logic [PIXEL_W-1:0]  a_eff, b_eff;
	logic [PIXEL_W-1:0]  window_q [WIN_TAPS];
	logic [PIXEL_W-1:0]  win_nx [WIN_TAPS];
	logic signed [PROD_W-1:0] prod_nx [WIN_TAPS];
	logic                emit_nx, int_nx, last_nx;
	logic [Y_OUT_W-1:0]  cx_nx, cy_nx;

	// Stage 2: products
	logic                v_s2;
	logic signed [PROD_W-1:0] prod_s2 [WIN_TAPS];
	logic                emit_s2, int_s2, last_s2, clrb_s2, clra_s2;
	logic [Y_OUT_W-1:0]  cx_s2, cy_s2;
	logic signed [ACC_W-1:0] acc_nx;

	// Stage 3: window sum
	logic                v_s3;
	logic signed [ACC_W-1:0] sum_s3;
	logic                emit_s3, int_s3, last_s3, clrb_s3, clra_s3;
	logic [Y_OUT_W-1:0]  cx_s3, cy_s3;
	logic signed [31:0]  sum_ext;
	logic signed [SUM_W-1:0] sat, raw, mn, mx;
	logic [CLIP_W-1:0]   clip;
	logic signed [SUM_W-1:0] min_q, max_q;
	c3cf_result_t        res_s3;

	// Output buffer
	c3cf_result_t        fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                push, pop, drop;
	c3cf_result_t        head;

	// ---------------------------------------------------------------- config
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q  <= '0;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg.valid) begin
			unique case (c3cf_reg_t'(cfg.index))
				REG_COEFF:  coeff_q  <= cfg.data[COEFF_REG_W-1:0];
				REG_WIDTH:  width_q  <= cfg.data[WIDTH_REG_W-1:0];
				REG_HEIGHT: height_q <= cfg.data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < WIDTH_REG_W'(MIN_SIZE)) begin
			eff_w = WIDTH_REG_W'(MIN_SIZE);
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_w = WIDTH_REG_W'(MAX_WIDTH);
		end else begin
			eff_w = width_q;
		end
		if (height_q < HEIGHT_REG_W'(MIN_SIZE)) begin
			eff_h = HEIGHT_REG_W'(MIN_SIZE);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			eff_h = HEIGHT_REG_W'(MAX_HEIGHT);
		end else begin
			eff_h = height_q;
		end
	end

	// Coefficient fields past the register's top bit read as zero.
	assign coeff_wide = {{CVEC_W{1'b0}}, coeff_q};
	assign coef_vec   = coeff_wide[CVEC_W-1:0];

	// ---------------------------------------------------------------- position
	assign pixels.ready = (occ_q < CNT_W'(FIFO_DEPTH));
	assign accept       = pixels.valid && pixels.ready;

	always_comb begin
		c_pre    = pixels.frame_start ? '0 : HEIGHT_REG_W'(col_q);
		r_pre    = pixels.frame_start ? '0 : HEIGHT_REG_W'(row_q);
		clrb_pre = pixels.frame_start;
		// A width or height lowered mid-frame moves the position on.
		if (c_pre >= HEIGHT_REG_W'(eff_w)) begin
			c_pre = '0;
			r_pre = r_pre + 1'b1;
		end
		if (r_pre >= eff_h) begin
			r_pre    = '0;
			clrb_pre = 1'b1;
		end
		c_nx     = c_pre + 1'b1;
		r_nx     = r_pre;
		clra_pre = 1'b0;
		if (c_nx >= HEIGHT_REG_W'(eff_w)) begin
			c_nx = '0;
			r_nx = r_pre + 1'b1;
			if (r_nx >= eff_h) begin
				r_nx     = '0;
				clra_pre = 1'b1;
			end
		end
	end

	// The item in stage 1 writes its column this cycle; a read of the same
	// column now would miss that write, so its data is bypassed.
	assign fwd_hit = v_s1 && (c_s1 == AW'(c_pre));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= AW'(c_nx);
			row_q <= Y_OUT_W'(r_nx);
		end
	end

	// ---------------------------------------------------------------- line stores
	c3cf_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_line_a (
		.clk   (clk),
		.we    (v_s1),
		.waddr (c_s1),
		.wdata (pix_s1),
		.re    (accept),
		.raddr (AW'(c_pre)),
		.rdata (rd_a)
	);

	c3cf_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_line_b (
		.clk   (clk),
		.we    (v_s1),
		.waddr (c_s1),
		.wdata (a_eff),
		.re    (accept),
		.raddr (AW'(c_pre)),
		.rdata (rd_b)
	);

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				fwd_s1 <= fwd_hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1   <= pixels.pixel;
			c_s1     <= AW'(c_pre);
			r_s1     <= Y_OUT_W'(r_pre);
			clrb_s1  <= clrb_pre;
			clra_s1  <= clra_pre;
			a_fwd_s1 <= pix_s1;
			b_fwd_s1 <= a_eff;
		end
	end

	assign a_eff = fwd_s1 ? a_fwd_s1 : rd_a;
	assign b_eff = fwd_s1 ? b_fwd_s1 : rd_b;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_nx[i*3]     = window_q[i*3+1];
			win_nx[i*3 + 1] = window_q[i*3+2];
		end
		win_nx[2] = b_eff;
		win_nx[5] = a_eff;
		win_nx[8] = pix_s1;
		for (int k = 0; k < WIN_TAPS; k++) begin
			prod_nx[k] = $signed({1'b0, win_nx[k]}) *
				$signed(coef_vec[k*COEF_BITS +: COEF_BITS]);
		end
	end

	always_comb begin
		emit_nx = ((c_s1 != '0) && (r_s1 != '0)) || ((c_s1 == '0) && (r_s1 >= 12'd2));
		int_nx  = (HEIGHT_REG_W'(c_s1) >= 13'd2) && (r_s1 >= 12'd2);
		if (c_s1 != '0) begin
			cx_nx = Y_OUT_W'(c_s1) - 1'b1;
			cy_nx = r_s1 - 12'd1;
		end else begin
			// A pixel in column 0 closes the right border centre two rows above it.
			cx_nx = eff_w - 1'b1;
			cy_nx = r_s1 - 12'd2;
		end
		last_nx = (HEIGHT_REG_W'(c_s1) == HEIGHT_REG_W'(eff_w) - 1'b1) &&
			(HEIGHT_REG_W'(r_s1) == eff_h - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN_TAPS; k++) begin
				window_q[k] <= '0;
			end
		end else if (v_s1) begin
			window_q <= win_nx;
		end
	end

	// ---------------------------------------------------------------- stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= prod_nx;
			emit_s2 <= emit_nx;
			int_s2  <= int_nx;
			last_s2 <= last_nx;
			clrb_s2 <= clrb_s1;
			clra_s2 <= clra_s1;
			cx_s2   <= cx_nx;
			cy_s2   <= cy_nx;
		end
	end

	always_comb begin
		acc_nx = '0;
		for (int k = 0; k < WIN_TAPS; k++) begin
			acc_nx = acc_nx + ACC_W'(prod_s2[k]);
		end
	end

	// ---------------------------------------------------------------- stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			sum_s3  <= acc_nx;
			emit_s3 <= emit_s2;
			int_s3  <= int_s2;
			last_s3 <= last_s2;
			clrb_s3 <= clrb_s2;
			clra_s3 <= clra_s2;
			cx_s3   <= cx_s2;
			cy_s3   <= cy_s2;
		end
	end

	always_comb begin
		sum_ext = 32'(sum_s3);
		if (sum_ext > SUM_HI) begin
			sat = SUM_MAX;
		end else if (sum_ext < SUM_LO) begin
			sat = SUM_MIN;
		end else begin
			sat = SUM_W'(sum_ext);
		end
		raw = int_s3 ? sat : '0;
		if (raw > SUM_W'(CLIP_HI)) begin
			clip = CLIP_W'(CLIP_HI);
		end else if (raw < 0) begin
			clip = '0;
		end else begin
			clip = raw[CLIP_W-1:0];
		end
		mn = clrb_s3 ? SUM_MAX : min_q;
		mx = clrb_s3 ? SUM_MIN : max_q;
		if (int_s3 && (raw < mn)) begin
			mn = raw;
		end
		if (int_s3 && (raw > mx)) begin
			mx = raw;
		end
		res_s3.out_x      = X_OUT_W'(cx_s3);
		res_s3.out_y      = cy_s3;
		res_s3.clipped    = clip;
		res_s3.raw_sum    = raw;
		res_s3.frame_min  = mn;
		res_s3.frame_max  = mx;
		res_s3.frame_last = last_s3;
	end

	// The last pixel of a frame restarts min/max for the next one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= SUM_MAX;
			max_q <= SUM_MIN;
		end else if (v_s3) begin
			min_q <= clra_s3 ? SUM_MAX : mn;
			max_q <= clra_s3 ? SUM_MIN : mx;
		end
	end

	// ---------------------------------------------------------------- output buffer
	assign push = v_s3 && emit_s3;
	assign drop = v_s3 && !emit_s3;
	assign pop  = results.valid && results.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
			// Every beat in flight holds a buffer slot until it leaves or is dropped.
			occ_q <= occ_q + CNT_W'(accept) - CNT_W'(pop) - CNT_W'(drop);
		end
	end

	assign head               = fifo_q[rd_ptr_q];
	assign results.valid      = (cnt_q != '0);
	assign results.out_x      = head.out_x;
	assign results.out_y      = head.out_y;
	assign results.clipped    = head.clipped;
	assign results.raw_sum    = head.raw_sum;
	assign results.frame_min  = head.frame_min;
	assign results.frame_max  = head.frame_max;
	assign results.frame_last = head.frame_last;

endmodule

FILE: src/c3cf_checker.sv
// Port-level checker for the filter, bound to the top level.
`include "assert_macros.svh"

module c3cf_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [c3cf_pkg::X_OUT_W-1:0]      out_x,
	input logic [c3cf_pkg::Y_OUT_W-1:0]      out_y,
	input logic [c3cf_pkg::CLIP_W-1:0]       clipped,
	input logic signed [c3cf_pkg::SUM_W-1:0] raw_sum,
	input logic signed [c3cf_pkg::SUM_W-1:0] frame_min,
	input logic signed [c3cf_pkg::SUM_W-1:0] frame_max,
	input logic                              frame_last
);
	import c3cf_pkg::*;

	logic [CLIP_W-1:0] exp_clip;
	logic              no_interior;

	always_comb begin
		if (raw_sum > SUM_W'(CLIP_HI)) begin
			exp_clip = CLIP_W'(CLIP_HI);
		end else if (raw_sum < 0) begin
			exp_clip = '0;
		end else begin
			exp_clip = raw_sum[CLIP_W-1:0];
		end
	end

	assign no_interior = (frame_min == SUM_MAX) && (frame_max == SUM_MIN);

	// A stalled result beat stays valid and keeps its position, raw sum and frame_last.
	`ASSERT_CLK(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) && $stable(raw_sum) && $stable(frame_last), "result changed while stalled")
	`ASSERT_CLK(a_clip_match, out_valid |-> clipped == exp_clip, "clipped value does not match raw sum")
	`ASSERT_CLK(a_raw_in_range, out_valid && raw_sum != 0 |-> frame_min <= raw_sum && raw_sum <= frame_max, "interior sum outside frame min/max")
	`ASSERT_CLK(a_minmax_order, out_valid |-> frame_min <= frame_max || no_interior, "frame min above frame max")

endmodule

bind conv3x3_clip_filter_unit c3cf_checker u_c3cf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.out_x      (results.out_x),
	.out_y      (results.out_y),
	.clipped    (results.clipped),
	.raw_sum    (results.raw_sum),
	.frame_min  (results.frame_min),
	.frame_max  (results.frame_max),
	.frame_last (results.frame_last)
);
